[rtl/core/acld_pkg.sv]
// Shared types, constants and keyword table for the ASCII command line decoder.
// No dependencies; every other file but acld_if imports this package.
`default_nettype none
package acld_pkg;

   localparam int LINE_CAPACITY = 63;
   localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W = $clog2(LINE_CAPACITY);
   localparam int KW_MAX = 11;
   localparam int KW_CNT_W = 4;
   localparam int KW_COUNT = 23;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;

   localparam logic [3:0] CMD_UNKNOWN    = 4'd0;
   localparam logic [3:0] CMD_GOTO       = 4'd1;
   localparam logic [3:0] CMD_STEP       = 4'd2;
   localparam logic [3:0] CMD_POS_QUERY  = 4'd3;
   localparam logic [3:0] CMD_SPEED      = 4'd4;
   localparam logic [3:0] CMD_PARK       = 4'd5;
   localparam logic [3:0] CMD_HALT       = 4'd6;
   localparam logic [3:0] CMD_CAL        = 4'd7;
   localparam logic [3:0] CMD_POS_READ   = 4'd8;
   localparam logic [3:0] CMD_MODE_SET   = 4'd9;
   localparam logic [3:0] CMD_MODE_QUERY = 4'd10;
   localparam logic [3:0] CMD_TEMP       = 4'd11;
   localparam logic [3:0] CMD_VOLT       = 4'd12;
   localparam logic [3:0] CMD_STATUS     = 4'd13;

   typedef logic [KW_MAX-1:0][7:0] kw_chars_type;

   // keywords right-aligned in 88 bits
   localparam logic [8*KW_MAX-1:0] KW_WORD [KW_COUNT] = '{
      "MOVE", "MOVETO", "MOVER", "MOVEBY", "POS", "GETPOS", "SPEED", "SETSPEED",
      "HOME", "STOP", "CAL", "CALIBRATE", "READ", "READPOS", "MODE", "SETMODE",
      "GETMODE", "TEMP", "TEMPERATURE", "VOLT", "VOLTAGE", "STATUS", "INFO"};
   localparam logic [KW_CNT_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd4, 4'd6, 4'd5, 4'd6, 4'd3, 4'd6, 4'd5, 4'd8, 4'd4, 4'd4, 4'd3, 4'd9,
      4'd4, 4'd7, 4'd4, 4'd7, 4'd7, 4'd4, 4'd11, 4'd4, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] KW_CODE [KW_COUNT] = '{
      CMD_GOTO, CMD_GOTO, CMD_STEP, CMD_STEP, CMD_POS_QUERY, CMD_POS_QUERY,
      CMD_SPEED, CMD_SPEED, CMD_PARK, CMD_HALT, CMD_CAL, CMD_CAL, CMD_POS_READ,
      CMD_POS_READ, CMD_MODE_SET, CMD_MODE_SET, CMD_MODE_QUERY, CMD_TEMP, CMD_TEMP,
      CMD_VOLT, CMD_VOLT, CMD_STATUS, CMD_STATUS};

   typedef struct packed {
      logic [3:0]         cmd_code;
      logic               ok;
      logic signed [31:0] pan_value;
      logic signed [31:0] tilt_value;
      logic signed [31:0] speed_value;
      logic signed [31:0] mode_value;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic             clr;
      logic [7:0]       wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } store_ctrl_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= CH_LC_A && c <= CH_LC_Z) ? (c - 8'd32) : c;
   endfunction

   function automatic logic [3:0] kw_lookup(input kw_chars_type kw,
                                            input logic [KW_CNT_W-1:0] len);
      logic [3:0] code;
      logic       hit;
      code = CMD_UNKNOWN;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (len == KW_LEN[k]);
         for (int i = 0; i < KW_MAX; i++) begin
            if (i < int'(KW_LEN[k])) begin
               if (to_upper(kw[i]) != KW_WORD[k][8*(int'(KW_LEN[k])-1-i) +: 8])
                  hit = 1'b0;
            end
         end
         if (hit) code = KW_CODE[k];
      end
      return code;
   endfunction

endpackage
`default_nettype wire

[rtl/core/acld_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// No dependencies.
`default_nettype none
interface acld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acld_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         cmd_code;
   logic               ok;
   logic signed [31:0] pan_value;
   logic signed [31:0] tilt_value;
   logic signed [31:0] speed_value;
   logic signed [31:0] mode_value;
   modport source (output valid, output cmd_code, output ok, output pan_value,
                   output tilt_value, output speed_value, output mode_value,
                   input ready);
   modport sink   (input valid, input cmd_code, input ok, input pan_value,
                   input tilt_value, input speed_value, input mode_value,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/ascii_command_line_decoder_unit.sv]
// Top level of the ASCII command line decoder: request handshake, line store,
// scanner and response register. Depends on acld_pkg, acld_if, acld_store, acld_scan.
//
//   channel | dir | payload                                       | handshake
//   req_ch  | in  | rx_byte[7:0]                                  | valid/ready
//   rsp_ch  | out | cmd_code, ok, pan/tilt/speed/mode_value[31:0] | valid/ready
//
// An ordinary byte is stored unless the line is full; '<' clears the line.
// A terminator on a non-empty line starts a scan of the line memory, one
// character per cycle through its read port. req_ch.ready is low after the
// terminator until the response is valid, and for a terminator while one waits.
// Synchronous active-high reset empties the line and drops any pending response.
`default_nettype none
module ascii_command_line_decoder_unit
   import acld_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   acld_req_if.sink   req_ch,
   acld_rsp_if.source rsp_ch
);
   store_ctrl_type   store_ctrl;
   logic [7:0]       rd_data;
   logic [LEN_W-1:0] length;
   logic [ADDR_W-1:0] rd_addr;
   logic             busy, done, is_term, accept, start;
   rsp_type          scan_rsp, rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   assign is_term = (req_ch.rx_byte == CH_LF) || (req_ch.rx_byte == CH_CR) ||
                    (req_ch.rx_byte == CH_GT);
   assign req_ch.ready = !busy && !(is_term && rsp_valid_ff);
   assign accept = req_ch.valid && req_ch.ready;
   assign start  = accept && is_term && (length != '0);

   always_comb begin
      store_ctrl.wr_en   = accept && !is_term && (req_ch.rx_byte != CH_LT);
      store_ctrl.clr     = accept && (is_term || req_ch.rx_byte == CH_LT);
      store_ctrl.wr_data = req_ch.rx_byte;
      store_ctrl.rd_addr = rd_addr;
   end

   acld_store u_store (
      .clock(clock), .reset(reset), .ctrl_i(store_ctrl),
      .rd_data_o(rd_data), .length_o(length)
   );

   acld_scan u_scan (
      .clock(clock), .reset(reset), .start_i(start), .len_i(length),
      .rd_data_i(rd_data), .rd_addr_o(rd_addr), .busy_o(busy),
      .done_o(done), .rsp_o(scan_rsp)
   );

   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (done) rsp_ff <= scan_rsp;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.cmd_code    = rsp_ff.cmd_code;
   assign rsp_ch.ok          = rsp_ff.ok;
   assign rsp_ch.pan_value   = rsp_ff.pan_value;
   assign rsp_ch.tilt_value  = rsp_ff.tilt_value;
   assign rsp_ch.speed_value = rsp_ff.speed_value;
   assign rsp_ch.mode_value  = rsp_ff.mode_value;
endmodule
`default_nettype wire

[rtl/core/acld_store.sv]
// Line store: character memory with registered read and the fill count.
// Depends on acld_pkg.
`default_nettype none
module acld_store
   import acld_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire store_ctrl_type   ctrl_i,
   output logic [7:0]            rd_data_o,
   output logic [LEN_W-1:0]      length_o
);
   logic [7:0]       mem [LINE_CAPACITY];
   logic [7:0]       rd_data_ff;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             do_wr;

   assign do_wr = ctrl_i.wr_en && (length_ff < LEN_W'(LINE_CAPACITY));

   always_comb begin
      length_in = length_ff;
      if (ctrl_i.clr) length_in = '0;
      else if (do_wr) length_in = length_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_wr && !ctrl_i.clr) mem[length_ff[ADDR_W-1:0]] <= ctrl_i.wr_data;
      rd_data_ff <= mem[ctrl_i.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) length_ff <= '0;
      else       length_ff <= length_in;
   end

   assign rd_data_o = rd_data_ff;
   assign length_o  = length_ff;
endmodule
`default_nettype wire

[rtl/core/acld_scan.sv]
// Line scanner: reads the stored line once, trims and matches the keyword,
// parses up to two integer parameters. Depends on acld_pkg.
`default_nettype none
module acld_scan
   import acld_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start_i,
   input  wire logic [LEN_W-1:0] len_i,
   input  wire logic [7:0]       rd_data_i,
   output logic [ADDR_W-1:0]     rd_addr_o,
   output logic                  busy_o,
   output logic                  done_o,
   output rsp_type               rsp_o
);
   typedef enum logic [1:0] {S_IDLE, S_READ, S_MATCH, S_EMIT} state_type;
   typedef enum logic [1:0] {P_WS, P_DIG, P_DONE} phase_type;

   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     idx_ff, idx_in, len_ff, len_in;
   logic                 dvld_ff, dvld_in;
   logic                 colon_ff, colon_in, ptext_ff, ptext_in;
   logic                 kw_go_ff, kw_go_in, kw_long_ff, kw_long_in;
   logic [KW_CNT_W-1:0]  kw_cnt_ff, kw_cnt_in, kw_len_ff, kw_len_in;
   kw_chars_type         kw_ff, kw_in;
   logic [1:0]           field_ff, field_in;
   phase_type            phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   logic [31:0]          mag_ff, mag_in, v0_ff, v0_in, v1_ff, v1_in, cur_val;
   logic [3:0]           code_ff, code_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 done_ff, done_in;
   logic [35:0]          mag_next;
   logic [7:0]           c;

   assign c        = rd_data_i;
   assign mag_next = {mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} + {28'd0, c - CH_ZERO};
   assign cur_val  = neg_ff ? (32'd0 - mag_ff)
                            : (mag_ff[31] ? 32'h7FFF_FFFF : mag_ff);

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; len_in = len_ff; dvld_in = 1'b0;
      colon_in = colon_ff; ptext_in = ptext_ff; kw_go_in = kw_go_ff;
      kw_long_in = kw_long_ff; kw_cnt_in = kw_cnt_ff; kw_len_in = kw_len_ff;
      kw_in = kw_ff; field_in = field_ff; phase_in = phase_ff; neg_in = neg_ff;
      mag_in = mag_ff; v0_in = v0_ff; v1_in = v1_ff; code_in = code_ff;
      rsp_in = rsp_ff; done_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               state_in = S_READ; idx_in = '0; len_in = len_i;
               colon_in = 1'b0; ptext_in = 1'b0; kw_go_in = 1'b0;
               kw_long_in = 1'b0; kw_cnt_in = '0; kw_len_in = '0;
               field_in = '0; phase_in = P_WS; neg_in = 1'b0; mag_in = '0;
               v0_in = '0; v1_in = '0;
            end
         end
         S_READ: begin
            if (idx_ff < len_ff) begin
               idx_in  = idx_ff + 1'b1;
               dvld_in = 1'b1;
            end else if (!dvld_ff) begin
               state_in = S_MATCH;
            end
            if (dvld_ff) begin
               if (!colon_ff) begin
                  if (c == CH_COLON) begin
                     colon_in = 1'b1;
                  end else if (kw_go_ff || !is_ws(c)) begin
                     kw_go_in = 1'b1;
                     if (kw_cnt_ff < KW_CNT_W'(KW_MAX)) kw_in[kw_cnt_ff] = c;
                     if (!is_ws(c)) begin
                        if (kw_cnt_ff >= KW_CNT_W'(KW_MAX)) kw_long_in = 1'b1;
                        else kw_len_in = kw_cnt_ff + 1'b1;
                     end
                     if (kw_cnt_ff <= KW_CNT_W'(KW_MAX)) kw_cnt_in = kw_cnt_ff + 1'b1;
                  end
               end else begin
                  ptext_in = 1'b1;
                  if (c == CH_COMMA) begin
                     if (field_ff == 2'd0) v0_in = cur_val;
                     if (field_ff == 2'd1) v1_in = cur_val;
                     if (field_ff != 2'd2) field_in = field_ff + 1'b1;
                     phase_in = P_WS; neg_in = 1'b0; mag_in = '0;
                  end else begin
                     case (phase_ff)
                        P_WS: begin
                           if (is_digit(c)) begin
                              phase_in = P_DIG; mag_in = {28'd0, c[3:0]};
                           end else if (c == CH_PLUS || c == CH_MINUS) begin
                              phase_in = P_DIG; neg_in = (c == CH_MINUS);
                           end else if (!is_ws(c)) begin
                              phase_in = P_DONE;
                           end
                        end
                        P_DIG: begin
                           if (is_digit(c)) begin
                              mag_in = (mag_next > 36'h0_8000_0000) ? 32'h8000_0000
                                                                    : mag_next[31:0];
                           end else begin
                              phase_in = P_DONE;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         S_MATCH: begin
            if (field_ff == 2'd0) v0_in = cur_val;
            if (field_ff == 2'd1) v1_in = cur_val;
            code_in  = kw_long_ff ? CMD_UNKNOWN : kw_lookup(kw_ff, kw_len_ff);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_in = '0;
            rsp_in.cmd_code = code_ff;
            case (code_ff)
               CMD_GOTO, CMD_STEP: begin
                  if (ptext_ff) begin
                     rsp_in.ok = 1'b1; rsp_in.pan_value = v0_ff; rsp_in.tilt_value = v1_ff;
                  end
               end
               CMD_SPEED: begin rsp_in.ok = 1'b1; rsp_in.speed_value = v0_ff; end
               CMD_MODE_SET: begin rsp_in.ok = 1'b1; rsp_in.mode_value = v0_ff; end
               CMD_UNKNOWN: rsp_in.ok = 1'b0;
               default: rsp_in.ok = 1'b1;
            endcase
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dvld_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dvld_ff  <= dvld_in;
         done_ff  <= done_in;
      end
      idx_ff <= idx_in; len_ff <= len_in; colon_ff <= colon_in; ptext_ff <= ptext_in;
      kw_go_ff <= kw_go_in; kw_long_ff <= kw_long_in; kw_cnt_ff <= kw_cnt_in;
      kw_len_ff <= kw_len_in; kw_ff <= kw_in; field_ff <= field_in;
      phase_ff <= phase_in; neg_ff <= neg_in; mag_ff <= mag_in;
      v0_ff <= v0_in; v1_ff <= v1_in; code_ff <= code_in; rsp_ff <= rsp_in;
   end

   assign rd_addr_o = idx_ff[ADDR_W-1:0];
   assign busy_o    = (state_ff != S_IDLE) || done_ff;
   assign done_o    = done_ff;
   assign rsp_o     = rsp_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_i |-> state_ff == S_IDLE) else $error("scan start while busy");
   a_done_after_emit: assert property (@(posedge clock) disable iff (reset)
      done_o |-> $past(state_ff) == S_EMIT) else $error("done without emit");
   a_read_in_line: assert property (@(posedge clock) disable iff (reset)
      dvld_in |-> idx_ff < len_ff) else $error("read past line end");
   a_kw_len_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MATCH |-> kw_len_ff <= KW_CNT_W'(KW_MAX)) else $error("keyword length");
endmodule
`default_nettype wire

[tb/acld_tb_pkg.sv]
// Predictor of the ASCII command line decoder for the testbench.
// Depends on acld_pkg for the command codes and the response type.
`timescale 1ns / 1ps
package acld_tb_pkg;
   import acld_pkg::*;

   function automatic logic ws_char(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] up_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic signed [31:0] atol_sat(input logic [7:0] text [$],
                                                  input int s, input int e);
      longint mag;
      logic   neg;
      mag = 0;
      neg = 1'b0;
      while (s < e && ws_char(text[s])) s++;
      if (s < e && (text[s] == "+" || text[s] == "-")) begin
         neg = (text[s] == "-");
         s++;
      end
      while (s < e && text[s] >= "0" && text[s] <= "9") begin
         mag = mag * 10 + (text[s] - "0");
         if (mag > 64'd2147483648) mag = 64'd2147483648;
         s++;
      end
      if (neg) return 32'(-mag);
      if (mag > 64'd2147483647) mag = 64'd2147483647;
      return 32'(mag);
   endfunction

   function automatic logic signed [31:0] nth_param(input logic [7:0] text [$],
                                                   input int s, input int e,
                                                   input int idx);
      int fld;
      int start;
      fld = 0;
      start = s;
      for (int i = s; i < e; i++) begin
         if (text[i] == ",") begin
            if (fld == idx) return atol_sat(text, start, i);
            fld++;
            start = i + 1;
         end
      end
      if (fld == idx) return atol_sat(text, start, e);
      return 0;
   endfunction

   function automatic logic [3:0] match_word(input string w);
      case (w)
         "MOVE", "MOVETO":         return CMD_GOTO;
         "MOVER", "MOVEBY":        return CMD_STEP;
         "POS", "GETPOS":          return CMD_POS_QUERY;
         "SPEED", "SETSPEED":      return CMD_SPEED;
         "HOME":                   return CMD_PARK;
         "STOP":                   return CMD_HALT;
         "CAL", "CALIBRATE":       return CMD_CAL;
         "READ", "READPOS":        return CMD_POS_READ;
         "MODE", "SETMODE":        return CMD_MODE_SET;
         "GETMODE":                return CMD_MODE_QUERY;
         "TEMP", "TEMPERATURE":    return CMD_TEMP;
         "VOLT", "VOLTAGE":        return CMD_VOLT;
         "STATUS", "INFO":         return CMD_STATUS;
         default:                  return CMD_UNKNOWN;
      endcase
   endfunction

   function automatic rsp_type decode_line(input logic [7:0] text [$]);
      rsp_type r;
      int      len, colon, ks, ke, ps;
      string   w;
      logic    bad;
      r = '0;
      len = text.size();
      colon = len;
      for (int i = 0; i < len; i++)
         if (text[i] == ":") begin
            colon = i;
            break;
         end
      ps = (colon < len) ? colon + 1 : len;
      ks = 0;
      ke = colon;
      while (ks < ke && ws_char(text[ks])) ks++;
      while (ke > ks && ws_char(text[ke-1])) ke--;
      w = "";
      bad = 1'b0;
      for (int i = ks; i < ke; i++) begin
         if (text[i] == 8'h00) bad = 1'b1;
         w = {w, string'(up_char(text[i]))};
      end
      r.cmd_code = bad ? CMD_UNKNOWN : match_word(w);
      case (r.cmd_code)
         CMD_UNKNOWN: ;
         CMD_GOTO, CMD_STEP:
            if (ps < len) begin
               r.pan_value = nth_param(text, ps, len, 0);
               r.tilt_value = nth_param(text, ps, len, 1);
               r.ok = 1'b1;
            end
         CMD_SPEED: begin
            r.speed_value = nth_param(text, ps, len, 0);
            r.ok = 1'b1;
         end
         CMD_MODE_SET: begin
            r.mode_value = nth_param(text, ps, len, 0);
            r.ok = 1'b1;
         end
         default: r.ok = 1'b1;
      endcase
      return r;
   endfunction
endpackage

[tb/ascii_command_line_decoder_unit_test.sv]
// Top of the decoder testbench: directed lines, then random command lines and raw
// bytes, with random gaps and stalls. Depends on acld_pkg, acld_if and acld_tb_pkg.
`timescale 1ns / 1ps
module ascii_command_line_decoder_unit_test;
   import acld_pkg::*;
   import acld_tb_pkg::*;

   typedef struct {
      string   text;
      logic    fixed;
      rsp_type want;
   } line_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   int   hold_cycles = 0;
   logic [7:0] line_buf [$];
   rsp_type    expected_cmds [$];
   rsp_type    pinned [$];
   logic       pinned_flag [$];
   logic       rsp_drain_on = 1'b1;

   acld_req_if req_ch ();
   acld_rsp_if rsp_ch ();

   ascii_command_line_decoder_unit i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source));

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
   end

   function automatic rsp_type mk(input logic [3:0] c, input logic k,
                                  input logic signed [31:0] p, input logic signed [31:0] t,
                                  input logic signed [31:0] s, input logic signed [31:0] m);
      rsp_type r;
      r.cmd_code = c; r.ok = k; r.pan_value = p;
      r.tilt_value = t; r.speed_value = s; r.mode_value = m;
      return r;
   endfunction

   // track line state at the moment a request is accepted
   always @(posedge clock) begin
      rsp_type r;
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (req_ch.rx_byte == CH_LF || req_ch.rx_byte == CH_CR ||
             req_ch.rx_byte == CH_GT) begin
            if (line_buf.size() > 0) begin
               r = decode_line(line_buf);
               if (pinned.size() > 0 && pinned_flag[0]) begin
                  if (r != pinned[0]) begin
                     $display("%0t predictor disagrees with table: exp %h got %h",
                              $time, pinned[0], r);
                     errors++;
                  end
                  r = pinned[0];
               end
               if (pinned.size() > 0) begin
                  void'(pinned.pop_front());
                  void'(pinned_flag.pop_front());
               end
               expected_cmds.push_back(r);
            end
            line_buf = {};
         end else if (req_ch.rx_byte == CH_LT) begin
            line_buf = {};
         end else if (line_buf.size() < LINE_CAPACITY) begin
            line_buf.push_back(req_ch.rx_byte);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = mk(rsp_ch.cmd_code, rsp_ch.ok, rsp_ch.pan_value, rsp_ch.tilt_value,
                  rsp_ch.speed_value, rsp_ch.mode_value);
         if (expected_cmds.size() == 0) begin
            $display("%0t unexpected response %h", $time, got);
            errors++;
         end else begin
            want = expected_cmds.pop_front();
            if (got.cmd_code != want.cmd_code || got.ok != want.ok ||
                got.pan_value != want.pan_value || got.tilt_value != want.tilt_value ||
                got.speed_value != want.speed_value || got.mode_value != want.mode_value) begin
               $display("%0t mismatch: exp code %0d ok %0d %0d %0d %0d %0d",
                        $time, want.cmd_code, want.ok, want.pan_value, want.tilt_value,
                        want.speed_value, want.mode_value);
               $display("%0t           got code %0d ok %0d %0d %0d %0d %0d",
                        $time, got.cmd_code, got.ok, got.pan_value, got.tilt_value,
                        got.speed_value, got.mode_value);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off when requested
   always @(posedge clock) begin
      int phase;
      phase = $urandom_range(0, 15);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!rsp_drain_on)
         rsp_ch.ready <= 1'b1;
      else
         rsp_ch.ready <= (phase < 11);
   end

   task automatic send_byte(input logic [7:0] b);
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   int burst_left = 0;

   task automatic offer(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_byte(b);
   endtask

   task automatic offer_text(input string s, input logic [7:0] term);
      for (int i = 0; i < s.len(); i++) offer(s[i]);
      offer(term);
   endtask

   task automatic wait_empty();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_cmds.size() > 0) @(posedge clock);
   endtask

   function automatic string rand_number();
      string s;
      int    n;
      s = "";
      case ($urandom_range(0, 5))
         0: s = " ";
         1: s = "\t";
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: s = {s, "-"};
         1: s = {s, "+"};
         default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      if ($urandom_range(0, 9) == 0) s = {s, "x7"};
      return s;
   endfunction

   function automatic string rand_line();
      string words [23];
      string s, w;
      words = '{"move", "MoveTo", "MOVER", "moveby", "pos", "GetPos", "speed",
                "SETSPEED", "home", "stop", "Cal", "calibrate", "read", "readpos",
                "mode", "SetMode", "getmode", "temp", "temperature", "volt",
                "voltage", "status", "info"};
      w = words[$urandom_range(0, 22)];
      if ($urandom_range(0, 7) == 0) w = {w, "Q"};
      s = ($urandom_range(0, 4) == 0) ? {" ", w, "\t"} : w;
      if ($urandom_range(0, 5) != 0) begin
         s = {s, ":", rand_number()};
         repeat ($urandom_range(0, 3)) s = {s, ",", rand_number()};
      end
      return s;
   endfunction

   initial begin
      line_row_type rows [$];
      logic [7:0]   terms [3];
      string        s;
      terms = '{CH_LF, CH_CR, CH_GT};
      rows = '{
         '{"HOME", 1'b1, mk(CMD_PARK, 1'b1, 0, 0, 0, 0)},
         '{"move:2147483647,-2147483648", 1'b1,
           mk(CMD_GOTO, 1'b1, 2147483647, 32'sh80000000, 0, 0)},
         '{"MOVER:99999999999,-99999999999", 1'b1,
           mk(CMD_STEP, 1'b1, 2147483647, 32'sh80000000, 0, 0)},
         '{"MOVE", 1'b1, mk(CMD_GOTO, 1'b0, 0, 0, 0, 0)},
         '{"MOVER:", 1'b1, mk(CMD_STEP, 1'b0, 0, 0, 0, 0)},
         '{"bogus", 1'b1, mk(CMD_UNKNOWN, 1'b0, 0, 0, 0, 0)},
         '{" setspeed :  +42", 1'b1, mk(CMD_SPEED, 1'b1, 0, 0, 42, 0)},
         '{"MODE:-7", 1'b1, mk(CMD_MODE_SET, 1'b1, 0, 0, 0, -7)},
         '{"moveto: 5", 1'b0, '0}, '{"MOVEBY:1,2,3", 1'b0, '0}, '{"pos", 1'b0, '0},
         '{"GETPOS", 1'b0, '0}, '{"speed", 1'b0, '0}, '{"stop", 1'b0, '0},
         '{"CAL", 1'b0, '0}, '{"calibrate", 1'b0, '0}, '{"READ", 1'b0, '0},
         '{"readpos", 1'b0, '0}, '{"SetMode:12a", 1'b0, '0}, '{"getmode", 1'b0, '0},
         '{"TEMP", 1'b0, '0}, '{"temperature", 1'b0, '0}, '{"volt", 1'b0, '0},
         '{"VOLTAGE", 1'b0, '0}, '{"status", 1'b0, '0}, '{"info", 1'b0, '0}};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty line terminators, cleared line, table rows, full line with dropped bytes
      offer(CH_LF);
      offer_text("junk", CH_LT);
      offer(CH_GT);
      foreach (rows[i]) begin
         pinned.push_back(rows[i].want);
         pinned_flag.push_back(rows[i].fixed);
         offer_text(rows[i].text, terms[i % 3]);
      end
      s = "STATUS:";
      for (int i = 0; i < 70; i++) s = {s, "9"};
      offer_text(s, CH_LF);
      for (int b = 0; b < 256; b++) offer(b[7:0]);
      offer(CH_CR);

      wait_empty();
      hold_cycles = 400;
      for (int n = 0; n < 950; ) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               offer(8'($urandom_range(0, 255)));
               n++;
            end
         end else begin
            s = rand_line();
            if ($urandom_range(0, 19) == 0) s = {s, "<"};
            offer_text(s, terms[$urandom_range(0, 2)]);
            n += s.len() + 1;
         end
         if (n > 450 && n < 500) wait_empty();
      end
      offer(CH_LF);

      req_ch.valid <= 1'b0;
      fork
         while (expected_cmds.size() > 0) @(posedge clock);
         begin
            repeat (200000) @(posedge clock);
            $display("Some tests failed");
            $finish;
         end
      join_any
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
